// File: rtl/ptq_pkg.sv
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types and constants for the periodic timer queue: result kinds,
// operation codes, controller states and the command and status words
// between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned PER_W       = 16;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned SLOT_W      = ID_W + PER_W + TIME_W;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_FLUSH
  } ptq_state_t;

  typedef struct packed {
    logic capture;
    logic tick_init;
    logic scan_clr;
    logic scan_rd;
    logic insert;
    logic fire;
    logic flush;
  } ptq_cmd_t;

  typedef struct packed {
    logic found;
    logic pend_vld;
    logic scan_end;
    logic cnt_last;
  } ptq_status_t;

endpackage

`default_nettype wire

// File: rtl/ptq_ctrl.sv
// ----------------------------------------------------------------------------
// ptq_ctrl
// Controller state machine: sequences insert handling, slot scan rounds,
// firing of the earliest expired timer and the final flush of a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire                 in_op,
  input  ptq_pkg::ptq_status_t sts,
  output ptq_pkg::ptq_cmd_t    cmd,
  output logic                busy
);

  ptq_pkg::ptq_state_t state_r;
  ptq_pkg::ptq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptq_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = (in_op == ptq_pkg::OP_TICK) ? ptq_pkg::ST_SCAN : ptq_pkg::ST_INSERT;
        end
      end
      ptq_pkg::ST_INSERT: state_nxt = ptq_pkg::ST_IDLE;
      ptq_pkg::ST_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = ptq_pkg::ST_DRAIN;
        end
      end
      ptq_pkg::ST_DRAIN: state_nxt = ptq_pkg::ST_DECIDE;
      ptq_pkg::ST_DECIDE: begin
        if (sts.found) begin
          state_nxt = sts.cnt_last ? ptq_pkg::ST_FLUSH : ptq_pkg::ST_SCAN;
        end else begin
          state_nxt = ptq_pkg::ST_IDLE;
        end
      end
      ptq_pkg::ST_FLUSH: state_nxt = ptq_pkg::ST_IDLE;
      default: state_nxt = ptq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ptq_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          if (in_op == ptq_pkg::OP_TICK) begin
            cmd.tick_init = 1'b1;
            cmd.scan_clr  = 1'b1;
          end
        end
      end
      ptq_pkg::ST_INSERT: cmd.insert = 1'b1;
      ptq_pkg::ST_SCAN:   cmd.scan_rd = 1'b1;
      ptq_pkg::ST_DRAIN:  cmd = '0;
      ptq_pkg::ST_DECIDE: begin
        if (sts.found) begin
          cmd.fire     = 1'b1;
          cmd.scan_clr = 1'b1;
        end else if (sts.pend_vld) begin
          cmd.flush = 1'b1;
        end
      end
      ptq_pkg::ST_FLUSH: cmd.flush = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/ptq_datapath.sv
// ----------------------------------------------------------------------------
// ptq_datapath
// Slot storage and arithmetic: slot memory with registered read, valid and
// fired flags, running minimum over a scan, re-arm with saturation, the
// pending fired word and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_datapath #(
  parameter int unsigned SLOTS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  ptq_pkg::ptq_cmd_t                cmd,
  output ptq_pkg::ptq_status_t             sts,
  input  wire  [ptq_pkg::ID_W-1:0]         in_timer_id,
  input  wire  [ptq_pkg::TIME_W-1:0]       in_first_expiry,
  input  wire  [ptq_pkg::PER_W-1:0]        in_reload_interval,
  input  wire  [ptq_pkg::TIME_W-1:0]       in_now_time,
  output logic                             out_strobe,
  output logic [ptq_pkg::KIND_W-1:0]       out_kind,
  output logic [ptq_pkg::ID_W-1:0]         out_fired_id,
  output logic [ptq_pkg::TIME_W-1:0]       out_fired_at,
  output logic                             out_last
);

  localparam int unsigned IDXW = $clog2(SLOTS);

  // captured input word
  logic [ptq_pkg::ID_W-1:0]   id_r;
  logic [ptq_pkg::TIME_W-1:0] first_r;
  logic [ptq_pkg::PER_W-1:0]  per_r;
  logic [ptq_pkg::TIME_W-1:0] now_r;

  logic [ptq_pkg::SLOT_W-1:0] slot_mem [SLOTS];
  logic [ptq_pkg::SLOT_W-1:0] rd_q;
  logic [SLOTS-1:0]           valid_r;
  logic [SLOTS-1:0]           done_r;

  logic [IDXW-1:0]            scan_cnt_r;
  logic [IDXW-1:0]            rd_idx_r;
  logic                       rd_vld_r;

  logic                       found_r;
  logic [IDXW-1:0]            best_idx_r;
  logic [ptq_pkg::TIME_W-1:0] best_exp_r;
  logic [ptq_pkg::ID_W-1:0]   best_id_r;
  logic [ptq_pkg::PER_W-1:0]  best_per_r;

  logic [ptq_pkg::CNT_W-1:0]  count_r;
  logic                       pend_vld_r;
  logic [ptq_pkg::ID_W-1:0]   pend_id_r;
  logic [ptq_pkg::TIME_W-1:0] pend_at_r;

  logic                       out_vld_r;
  logic [ptq_pkg::KIND_W-1:0] out_kind_r;
  logic [ptq_pkg::ID_W-1:0]   out_id_r;
  logic [ptq_pkg::TIME_W-1:0] out_at_r;
  logic                       out_last_r;

  logic [ptq_pkg::ID_W-1:0]   rd_id;
  logic [ptq_pkg::PER_W-1:0]  rd_per;
  logic [ptq_pkg::TIME_W-1:0] rd_exp;
  logic                       cand;

  logic                       free_found;
  logic [IDXW-1:0]            free_idx;

  logic [ptq_pkg::TIME_W:0]   rearm_sum;
  logic [ptq_pkg::TIME_W-1:0] rearm_exp;

  logic                       mem_we;
  logic [IDXW-1:0]            mem_wa;
  logic [ptq_pkg::SLOT_W-1:0] mem_wd;

  assign {rd_id, rd_per, rd_exp} = rd_q;

  assign cand = rd_vld_r && valid_r[rd_idx_r] && !done_r[rd_idx_r] && (rd_exp <= now_r)
                && (!found_r || (rd_exp < best_exp_r));

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDXW'(i);
      end
    end
  end

  assign rearm_sum = {1'b0, now_r} + {{(ptq_pkg::TIME_W + 1 - ptq_pkg::PER_W){1'b0}}, best_per_r};
  assign rearm_exp = rearm_sum[ptq_pkg::TIME_W] ? {ptq_pkg::TIME_W{1'b1}}
                                               : rearm_sum[ptq_pkg::TIME_W-1:0];

  always_comb begin
    mem_we = 1'b0;
    mem_wa = best_idx_r;
    mem_wd = {best_id_r, best_per_r, rearm_exp};
    if (cmd.insert && free_found) begin
      mem_we = 1'b1;
      mem_wa = free_idx;
      mem_wd = {id_r, per_r, first_r};
    end else if (cmd.fire && (best_per_r != '0)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_wa] <= mem_wd;
    end
    if (cmd.scan_rd) begin
      rd_q <= slot_mem[scan_cnt_r];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_r    <= in_timer_id;
      first_r <= in_first_expiry;
      per_r   <= in_reload_interval;
      now_r   <= in_now_time;
    end
    if (cmd.scan_rd) begin
      rd_idx_r <= scan_cnt_r;
    end
    if (cand) begin
      best_idx_r <= rd_idx_r;
      best_exp_r <= rd_exp;
      best_id_r  <= rd_id;
      best_per_r <= rd_per;
    end
    if (cmd.fire) begin
      pend_id_r <= best_id_r;
      pend_at_r <= best_exp_r;
    end
    if (cmd.insert) begin
      out_kind_r <= free_found ? ptq_pkg::KIND_ACCEPTED : ptq_pkg::KIND_REJECTED;
      out_id_r   <= id_r;
      out_at_r   <= first_r;
      out_last_r <= 1'b1;
    end else if (cmd.fire || cmd.flush) begin
      out_kind_r <= ptq_pkg::KIND_FIRED;
      out_id_r   <= pend_id_r;
      out_at_r   <= pend_at_r;
      out_last_r <= cmd.flush;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      done_r     <= '0;
      scan_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
      found_r    <= 1'b0;
      count_r    <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      rd_vld_r  <= cmd.scan_rd;
      out_vld_r <= cmd.insert || cmd.flush || (cmd.fire && pend_vld_r);
      if (cmd.tick_init) begin
        done_r     <= '0;
        count_r    <= '0;
        pend_vld_r <= 1'b0;
      end
      if (cmd.scan_clr) begin
        scan_cnt_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
        if (cand) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.insert && free_found) begin
        valid_r[free_idx] <= 1'b1;
      end
      if (cmd.fire) begin
        done_r[best_idx_r] <= 1'b1;
        count_r            <= count_r + 1'b1;
        pend_vld_r         <= 1'b1;
        if (best_per_r == '0) begin
          valid_r[best_idx_r] <= 1'b0;
        end
      end
      if (cmd.flush) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  assign sts.found    = found_r;
  assign sts.pend_vld = pend_vld_r;
  assign sts.scan_end = (scan_cnt_r == IDXW'(SLOTS - 1));
  assign sts.cnt_last = (count_r == ptq_pkg::CNT_W'(ptq_pkg::MAX_RESULTS - 1));

  assign out_strobe   = out_vld_r;
  assign out_kind     = out_kind_r;
  assign out_fired_id = out_id_r;
  assign out_fired_at = out_at_r;
  assign out_last     = out_last_r;

  a_fire_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |-> found_r && valid_r[best_idx_r] && !done_r[best_idx_r])
    else $error("fire on a slot that is not a live candidate");

  a_flush_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> pend_vld_r)
    else $error("flush without a pending fired word");

  a_insert_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_kind_r != ptq_pkg::KIND_FIRED) |-> out_last_r)
    else $error("insert answer not marked last");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ptq_pkg::CNT_W'(ptq_pkg::MAX_RESULTS))
    else $error("fire count beyond result limit");

  a_fired_slot_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |=> done_r[$past(best_idx_r)])
    else $error("fired slot not marked for this tick");

endmodule

`default_nettype wire

// File: rtl/periodic_timer_queue.sv
// ----------------------------------------------------------------------------
// periodic_timer_queue
// Store of SLOTS software timers. Insert words place a timer in the lowest
// free slot; tick words fire expired timers earliest first and re-arm
// periodic ones.
// ----------------------------------------------------------------------------
// insert: the word is captured at start and the result loaded in the INSERT state,
// busy high there; tick: each scan round reads one slot per cycle from the slot memory;
//   n firings take n+1 rounds, or 16 rounds and then the FLUSH state when n hits 16
// each fired word is held pending and leaves when the next fires, the last at flush
// the receiver cannot stall: every result strobe lasts exactly one cycle
// reset clears the slot valid flags at once; slot contents are not cleared
`default_nettype none

module periodic_timer_queue #(
  parameter int unsigned SLOTS = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire                               in_op,
  input  wire  [ptq_pkg::ID_W-1:0]          in_timer_id,
  input  wire  [ptq_pkg::TIME_W-1:0]        in_first_expiry,
  input  wire  [ptq_pkg::PER_W-1:0]         in_reload_interval,
  input  wire  [ptq_pkg::TIME_W-1:0]        in_now_time,
  output logic                              out_strobe,
  output logic [ptq_pkg::KIND_W-1:0]        out_kind,
  output logic [ptq_pkg::ID_W-1:0]          out_fired_id,
  output logic [ptq_pkg::TIME_W-1:0]        out_fired_at,
  output logic                              out_last
);

  ptq_pkg::ptq_cmd_t    cmd;
  ptq_pkg::ptq_status_t sts;

  ptq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ptq_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_timer_id        (in_timer_id),
    .in_first_expiry    (in_first_expiry),
    .in_reload_interval (in_reload_interval),
    .in_now_time        (in_now_time),
    .out_strobe         (out_strobe),
    .out_kind           (out_kind),
    .out_fired_id       (out_fired_id),
    .out_fired_at       (out_fired_at),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire

// File: tb/periodic_timer_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_timer_queue_tb
// Self-checking bench for the periodic timer queue. A short stimulus table
// covers field extremes, store full, duplicate ids, ties, saturated re-arm
// and a tick firing every slot. Random insert and tick traffic follows in
// three idling phases. Every word is checked against a timer store
// predictor kept in step at each accepted start.
// ----------------------------------------------------------------------------
module periodic_timer_queue_tb;

  localparam int unsigned SLOT_N      = 16;
  localparam int          PHASE_LEN   = 94;
  localparam int unsigned ID_W        = ptq_pkg::ID_W;
  localparam int unsigned TIME_W      = ptq_pkg::TIME_W;
  localparam int unsigned PER_W       = ptq_pkg::PER_W;
  localparam int unsigned KIND_W      = ptq_pkg::KIND_W;
  localparam int unsigned MAX_RESULTS = ptq_pkg::MAX_RESULTS;

  typedef struct {
    logic              op;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] first;
    logic [PER_W-1:0]  per;
    logic [TIME_W-1:0] now;
  } timer_word_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] at;
    logic              last;
  } timer_result_t;

  typedef struct {
    timer_word_t   word;
    int            reps;
    bit            typed;
    int            n_typed;
    timer_result_t res;
  } directed_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_op;
  logic [ID_W-1:0]   in_timer_id;
  logic [TIME_W-1:0] in_first_expiry;
  logic [PER_W-1:0]  in_reload_interval;
  logic [TIME_W-1:0] in_now_time;
  logic              out_strobe;
  logic [KIND_W-1:0] out_kind;
  logic [ID_W-1:0]   out_fired_id;
  logic [TIME_W-1:0] out_fired_at;
  logic              out_last;

  logic              slot_live   [SLOT_N];
  logic [TIME_W-1:0] slot_due    [SLOT_N];
  logic [PER_W-1:0]  slot_reload [SLOT_N];
  logic [ID_W-1:0]   slot_tag    [SLOT_N];

  timer_result_t     awaited_words [$];
  directed_row_t     script [$];
  logic [TIME_W-1:0] wall_time;
  int                fill_left;
  int                mismatch_cnt;

  periodic_timer_queue #(.SLOTS(SLOT_N)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_timer_id        (in_timer_id),
    .in_first_expiry    (in_first_expiry),
    .in_reload_interval (in_reload_interval),
    .in_now_time        (in_now_time),
    .out_strobe         (out_strobe),
    .out_kind           (out_kind),
    .out_fired_id       (out_fired_id),
    .out_fired_at       (out_fired_at),
    .out_last           (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // timer store: insert into lowest free slot, or fire expired earliest first
  task automatic advance_timers(input timer_word_t w, input bit keep, output int n);
    int            i;
    int            k;
    int            free_idx;
    int            best;
    bit            fired [SLOT_N];
    logic [TIME_W:0] sum;
    timer_result_t r;
    timer_result_t fire_list [MAX_RESULTS];
    n = 0;
    if (w.op == ptq_pkg::OP_INSERT) begin
      free_idx = -1;
      for (i = 0; i < SLOT_N; i++) begin
        if (!slot_live[i] && free_idx < 0) free_idx = i;
      end
      r.kind = (free_idx < 0) ? ptq_pkg::KIND_REJECTED : ptq_pkg::KIND_ACCEPTED;
      r.id   = w.id;
      r.at   = w.first;
      r.last = 1'b1;
      if (free_idx >= 0) begin
        slot_live[free_idx]   = 1'b1;
        slot_due[free_idx]    = w.first;
        slot_reload[free_idx] = w.per;
        slot_tag[free_idx]    = w.id;
      end
      if (keep) awaited_words.push_back(r);
      n = 1;
    end else begin
      for (i = 0; i < SLOT_N; i++) fired[i] = 1'b0;
      while (n < MAX_RESULTS) begin
        best = -1;
        for (i = 0; i < SLOT_N; i++) begin
          if (slot_live[i] && !fired[i] && slot_due[i] <= w.now &&
              (best < 0 || slot_due[i] < slot_due[best])) best = i;
        end
        if (best < 0) break;
        fired[best]     = 1'b1;
        fire_list[n].kind = ptq_pkg::KIND_FIRED;
        fire_list[n].id   = slot_tag[best];
        fire_list[n].at   = slot_due[best];
        fire_list[n].last = 1'b0;
        n++;
        if (slot_reload[best] == '0) begin
          slot_live[best] = 1'b0;
        end else begin
          sum = {1'b0, w.now} + {{(TIME_W + 1 - PER_W){1'b0}}, slot_reload[best]};
          slot_due[best] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
        end
      end
      for (k = 0; k < n; k++) begin
        fire_list[k].last = (k == n - 1);
        if (keep) awaited_words.push_back(fire_list[k]);
      end
    end
  endtask

  task automatic drive_word(input timer_word_t w, input int idle_pct, input bit typed,
                            input int n_typed, input timer_result_t typed_res);
    int n;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_op              <= w.op;
    in_timer_id        <= w.id;
    in_first_expiry    <= w.first;
    in_reload_interval <= w.per;
    in_now_time        <= w.now;
    do @(posedge clk); while (busy);
    advance_timers(w, !typed, n);
    if (typed && n_typed > 0) awaited_words.push_back(typed_res);
  endtask

  task automatic settle_results();
    start <= 1'b0;
    do @(posedge clk); while (awaited_words.size() != 0);
  endtask

  task automatic add_row(input logic op, input logic [ID_W-1:0] id,
                         input logic [TIME_W-1:0] first, input logic [PER_W-1:0] per,
                         input logic [TIME_W-1:0] now, input int reps, input bit typed,
                         input int n_typed, input logic [KIND_W-1:0] kind,
                         input logic [ID_W-1:0] res_id, input logic [TIME_W-1:0] res_at);
    directed_row_t row;
    row.word.op    = op;
    row.word.id    = id;
    row.word.first = first;
    row.word.per   = per;
    row.word.now   = now;
    row.reps       = reps;
    row.typed      = typed;
    row.n_typed    = n_typed;
    row.res.kind   = kind;
    row.res.id     = res_id;
    row.res.at     = res_at;
    row.res.last   = 1'b1;
    script.push_back(row);
  endtask

  task automatic pick_random_word(output timer_word_t w);
    int i;
    int roll;
    int periodic_all;
    int periodic_near;
    periodic_all  = 0;
    periodic_near = 0;
    for (i = 0; i < SLOT_N; i++) begin
      if (slot_live[i] && slot_reload[i] != '0) begin
        periodic_all++;
        if (slot_due[i] <= wall_time + 32'd70000) periodic_near++;
      end
    end
    w.op    = ptq_pkg::OP_INSERT;
    w.id    = ID_W'($urandom);
    w.first = TIME_W'($urandom);
    w.per   = PER_W'($urandom);
    w.now   = TIME_W'($urandom);
    roll    = (fill_left > 0) ? 100 : int'($urandom_range(99));
    if (roll >= 97) begin
      // burst of far one-shots, runs the store into full
      if (fill_left == 0) fill_left = 18;
      fill_left--;
      w.first = wall_time + 32'd200 + TIME_W'($urandom_range(0, 255));
      w.per   = '0;
    end else if (roll < 48) begin
      w.first = wall_time - 32'd16 + TIME_W'($urandom_range(0, 96));
      if (periodic_all >= 10 || periodic_near >= 4 || $urandom_range(3) != 0) begin
        w.per = '0;
      end else if ($urandom_range(4) != 0) begin
        w.per = PER_W'($urandom_range(1, 48));
      end
    end else if (roll < 84) begin
      w.op      = ptq_pkg::OP_TICK;
      wall_time = wall_time + TIME_W'($urandom_range(0, 24));
      w.now     = wall_time;
    end else if (roll < 90) begin
      if (periodic_all >= 10 || periodic_near >= 4) w.per = '0;
    end else if (roll < 94) begin
      w.op = ptq_pkg::OP_TICK;
    end else begin
      w.op  = ptq_pkg::OP_TICK;
      w.now = '1;
    end
  endtask

  always @(posedge clk) begin : result_check
    timer_result_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (awaited_words.size() == 0) begin
        log_mismatch($sformatf("unexpected word kind=%0d id=%h at=%h last=%b",
                               out_kind, out_fired_id, out_fired_at, out_last));
      end else begin
        want = awaited_words.pop_front();
        if (out_kind !== want.kind)
          log_mismatch($sformatf("kind %0d, want %0d", out_kind, want.kind));
        if (out_fired_id !== want.id)
          log_mismatch($sformatf("fired_id %h, want %h", out_fired_id, want.id));
        if (out_fired_at !== want.at)
          log_mismatch($sformatf("fired_at %h, want %h", out_fired_at, want.at));
        if (out_last !== want.last)
          log_mismatch($sformatf("last %b, want %b", out_last, want.last));
      end
    end
  end

  initial begin : stimulus
    timer_word_t   w;
    timer_result_t no_res;
    int            r;
    int            k;
    int            phase;
    int            idle_pct;
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_op              <= ptq_pkg::OP_INSERT;
    in_timer_id        <= '0;
    in_first_expiry    <= '0;
    in_reload_interval <= '0;
    in_now_time        <= '0;
    mismatch_cnt = 0;
    fill_left    = 0;
    wall_time    = 32'd1000 + TIME_W'($urandom_range(0, 4000));
    no_res       = '{ptq_pkg::KIND_FIRED, '0, '0, 1'b0};
    for (k = 0; k < SLOT_N; k++) slot_live[k] = 1'b0;

    // empty store, extremes, ties, duplicate ids, saturated re-arm, full store
    add_row(ptq_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1, 1, 0,
            ptq_pkg::KIND_FIRED, 16'h0000, 32'h0000_0000);
    add_row(ptq_pkg::OP_INSERT, 16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1, 1, 1,
            ptq_pkg::KIND_ACCEPTED, 16'h0000, 32'h0000_0000);
    add_row(ptq_pkg::OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, 1, 1, 1,
            ptq_pkg::KIND_ACCEPTED, 16'hFFFF, 32'hFFFF_FFFF);
    add_row(ptq_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1, 1, 1,
            ptq_pkg::KIND_FIRED, 16'h0000, 32'h0000_0000);
    add_row(ptq_pkg::OP_INSERT, 16'h1234, 32'h0000_0064, 16'hFFFF, 32'h0000_0000, 1, 1, 1,
            ptq_pkg::KIND_ACCEPTED, 16'h1234, 32'h0000_0064);
    add_row(ptq_pkg::OP_INSERT, 16'h00AA, 32'h0000_0064, 16'h0000, 32'h0000_0000, 1, 0, 0,
            ptq_pkg::KIND_FIRED, '0, '0);
    add_row(ptq_pkg::OP_INSERT, 16'h1234, 32'h0000_0032, 16'h0000, 32'h0000_0000, 1, 0, 0,
            ptq_pkg::KIND_FIRED, '0, '0);
    add_row(ptq_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 16'h0000, 32'h0000_0064, 1, 0, 0,
            ptq_pkg::KIND_FIRED, '0, '0);
    add_row(ptq_pkg::OP_INSERT, 16'h5A5A, 32'hFFFF_FFF0, 16'h0020, 32'h0000_0000, 1, 0, 0,
            ptq_pkg::KIND_FIRED, '0, '0);
    add_row(ptq_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 16'h0000, 32'hFFFF_FFF8, 1, 0, 0,
            ptq_pkg::KIND_FIRED, '0, '0);
    add_row(ptq_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF, 1, 0, 0,
            ptq_pkg::KIND_FIRED, '0, '0);
    add_row(ptq_pkg::OP_INSERT, 16'h0100, 32'h0000_0200, 16'h0000, 32'h0000_0000, 14, 0, 0,
            ptq_pkg::KIND_FIRED, '0, '0);
    add_row(ptq_pkg::OP_INSERT, 16'hBEEF, 32'h0000_0BAD, 16'h8001, 32'h0000_0000, 1, 1, 1,
            ptq_pkg::KIND_REJECTED, 16'hBEEF, 32'h0000_0BAD);
    add_row(ptq_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF, 1, 0, 0,
            ptq_pkg::KIND_FIRED, '0, '0);
    add_row(ptq_pkg::OP_TICK,   16'h0000, 32'h0000_0000, 16'h0000, 32'hFFFF_FFFF, 1, 0, 0,
            ptq_pkg::KIND_FIRED, '0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < script.size(); r++) begin
      for (k = 0; k < script[r].reps; k++) begin
        w       = script[r].word;
        w.id    = w.id + ID_W'(k);
        w.first = w.first + TIME_W'(k);
        drive_word(w, 36, script[r].typed, script[r].n_typed, script[r].res);
      end
    end

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 36 : (phase == 1) ? 60 : 0;
      settle_results();
      repeat (PHASE_LEN + ((phase == 2) ? 1 : 0)) begin
        pick_random_word(w);
        drive_word(w, idle_pct, 1'b0, 0, no_res);
      end
    end

    settle_results();
    repeat (400) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
